/* sv/mfrl_pkg.sv */
// ----------------------------------------------------------------------------
// mfrl_pkg
// field widths, register indexes, reset values and the result type of the
// motor fault retry lockout block
// ----------------------------------------------------------------------------
package mfrl_pkg;

    localparam int FAULT_ID_W  = 4;
    localparam int BUDGET_W    = 8;
    localparam int TIMER_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS = 1'd1;

    // item kinds
    localparam logic KIND_PROTECT = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // reset values: three retries, twelve hours of 100 ms ticks
    localparam logic [BUDGET_W-1:0] RETRY_LIMIT_RESET   = 8'd3;
    localparam logic [TIMER_W-1:0]  RELEASE_TICKS_RESET = TIMER_W'(12 * 60 * 60 * 10);

    typedef struct packed {
        logic fault_active;
        logic clear_request;
        logic protect_request;
    } result_t;

endpackage

/* sv/motor_fault_retry_lockout_core.sv */
// ----------------------------------------------------------------------------
// motor_fault_retry_lockout_core
// per-fault-id retry budgets with error lockout and a timed release
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each accepted beat is handled in the cycle it is
// accepted: the budgets and the result are stored at that edge, the result in
// the skid stage if the output is held, so a new beat can be taken every cycle
// while in_stall is low. Behind the output register a one-deep skid stage holds
// a result while out_stall is high; in_stall rises only once both are full,
// which means the block keeps accepting for one beat after the output side
// stalls. There is no clearing pass after reset: budgets come out of reset at
// the retry limit. Budgets live in flip-flops for fault ids 1 to 15 (or fewer);
// ids at or above NUM_FAULT_IDS count as no fault, and the ids above 15 that a
// 4-bit fault_id can never name share one register, as they only ever take
// refill values. Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module motor_fault_retry_lockout_core #(
    parameter int NUM_FAULT_IDS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [mfrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mfrl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [mfrl_pkg::FAULT_ID_W-1:0]      fault_id,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 fault_active,
    output logic                                 clear_request,
    output logic                                 protect_request
);

    localparam int BW = mfrl_pkg::BUDGET_W;
    localparam int TW = mfrl_pkg::TIMER_W;
    localparam int ID_SPAN = 2 ** mfrl_pkg::FAULT_ID_W;
    // ids that fault_id can address and that are in range
    localparam int LOW_IDS = (NUM_FAULT_IDS < ID_SPAN) ? NUM_FAULT_IDS : ID_SPAN;
    localparam int IDX_W = $clog2(LOW_IDS);

    // configuration registers
    logic [BW-1:0] retry_limit_reg;
    logic [TW-1:0] release_ticks_reg;

    // budget state, entry 0 (no fault) is not stored
    logic [BW-1:0] protect_budget_reg  [1:LOW_IDS-1];
    logic [BW-1:0] protect_budget_next [1:LOW_IDS-1];
    logic [BW-1:0] error_budget_reg    [1:LOW_IDS-1];
    logic [BW-1:0] error_budget_next   [1:LOW_IDS-1];

    logic [mfrl_pkg::FAULT_ID_W-1:0] latched_fault_reg, latched_fault_next;
    // error budget of the latched id is zero
    logic                            latch_exhausted_reg, latch_exhausted_next;
    logic [TW-1:0]                   release_timer_reg, release_timer_next;

    // output register and skid stage
    logic                  out_valid_reg, out_valid_next;
    mfrl_pkg::result_t     out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    mfrl_pkg::result_t     skid_data_reg, skid_data_next;

    logic                  in_accept;
    logic                  id_ok;
    logic [IDX_W-1:0]      idx;
    logic [BW-1:0]         pb_sel;
    logic [BW-1:0]         eb_sel;
    logic                  any_used;
    logic                  upper_used;
    logic                  refill;
    mfrl_pkg::result_t     result;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= mfrl_pkg::RETRY_LIMIT_RESET;
            release_ticks_reg <= mfrl_pkg::RELEASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfrl_pkg::REG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[BW-1:0];
                mfrl_pkg::REG_RELEASE_TICKS: release_ticks_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // fault id decode, out-of-range ids act as no fault
    assign id_ok  = (fault_id != '0) && (int'(fault_id) < NUM_FAULT_IDS);
    assign idx    = fault_id[IDX_W-1:0];
    assign pb_sel = protect_budget_reg[idx];
    assign eb_sel = error_budget_reg[idx];

    // ids above what fault_id can name only ever hold a refill value
    generate
        if (NUM_FAULT_IDS > LOW_IDS)
        begin : g_upper
            logic [BW-1:0] upper_fill_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    upper_fill_reg <= mfrl_pkg::RETRY_LIMIT_RESET;
                else if (refill)
                    upper_fill_reg <= retry_limit_reg;
            end

            assign upper_used = upper_fill_reg < retry_limit_reg;
        end
        else
        begin : g_no_upper
            assign upper_used = 1'b0;
        end
    endgenerate

    // any budget below the retry limit, parallel compare and or-reduce
    always_comb
    begin
        any_used = upper_used;
        for (int i = 1; i < LOW_IDS; i++)
        begin
            if (error_budget_reg[i] < retry_limit_reg || protect_budget_reg[i] < retry_limit_reg)
                any_used = 1'b1;
        end
    end

    // per-beat state update and result
    always_comb
    begin
        protect_budget_next  = protect_budget_reg;
        error_budget_next    = error_budget_reg;
        latched_fault_next   = latched_fault_reg;
        latch_exhausted_next = latch_exhausted_reg;
        release_timer_next   = release_timer_reg;
        refill               = 1'b0;
        result               = '0;

        if (in_accept)
        begin
            if (kind == mfrl_pkg::KIND_PROTECT)
            begin
                if (id_ok)
                begin
                    latched_fault_next = fault_id;
                    if (pb_sel != '0)
                    begin
                        // retry left: spend one and ask for a clear
                        protect_budget_next[idx] = pb_sel - BW'(1);
                        latch_exhausted_next     = (eb_sel == '0);
                        result.clear_request     = 1'b1;
                    end
                    else
                    begin
                        // retries spent: refill, charge the error budget, protect
                        protect_budget_next[idx] = retry_limit_reg;
                        if (eb_sel != '0)
                            error_budget_next[idx] = eb_sel - BW'(1);
                        latch_exhausted_next   = (eb_sel <= BW'(1));
                        result.protect_request = 1'b1;
                        result.fault_active    = 1'b1;
                    end
                end
            end
            else
            begin
                if (latched_fault_reg != '0)
                begin
                    // locked out while the latched id has no error budget left
                    if (latch_exhausted_reg)
                        result.fault_active = 1'b1;
                    else
                        latched_fault_next = '0;
                end
                else
                begin
                    // release timer, refill everything on expiry
                    refill = (release_timer_reg == '0);
                    if (refill)
                    begin
                        for (int i = 1; i < LOW_IDS; i++)
                        begin
                            protect_budget_next[i] = retry_limit_reg;
                            error_budget_next[i]   = retry_limit_reg;
                        end
                    end
                    // reload while nothing is used; a refill leaves nothing used
                    if (refill || !any_used)
                        release_timer_next = release_ticks_reg;
                    else
                        release_timer_next = release_timer_reg - TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i < LOW_IDS; i++)
            begin
                protect_budget_reg[i] <= mfrl_pkg::RETRY_LIMIT_RESET;
                error_budget_reg[i]   <= mfrl_pkg::RETRY_LIMIT_RESET;
            end
            latched_fault_reg   <= '0;
            latch_exhausted_reg <= 1'b0;
            release_timer_reg   <= mfrl_pkg::RELEASE_TICKS_RESET;
        end
        else
        begin
            protect_budget_reg  <= protect_budget_next;
            error_budget_reg    <= error_budget_next;
            latched_fault_reg   <= latched_fault_next;
            latch_exhausted_reg <= latch_exhausted_next;
            release_timer_reg   <= release_timer_next;
        end
    end

    // output register with skid stage behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_valid_reg && out_stall)
        begin
            // output held: a new beat parks in the skid stage
            if (in_accept)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = in_accept;
            out_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid       = out_valid_reg;
    assign fault_active    = out_data_reg.fault_active;
    assign clear_request   = out_data_reg.clear_request;
    assign protect_request = out_data_reg.protect_request;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for motor_fault_retry_lockout_core: a directed table of
// beats and register writes, then phases of random fault bursts and quiet
// tick runs under several retry and release settings, every result checked
// against the table's value or a cycle-free predictor of the budgets, the latch and the timer
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_IDS     = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_BEATS = 131;
    localparam int NUM_PHASES  = 8;
    localparam int PRESSURE_AT = 750;

    // directed table rows: a beat to send or a register to write
    typedef enum logic {ROW_BEAT, ROW_WRITE} row_op_t;

    typedef struct packed {
        row_op_t                          op;
        logic                             k;
        logic [mfrl_pkg::FAULT_ID_W-1:0]  id;
        logic                             has_want;
        mfrl_pkg::result_t                want;
        logic [mfrl_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [mfrl_pkg::CFG_DATA_W-1:0]  reg_val;
    } stim_row_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, all driven to known values from time zero
    logic                             cfg_we    = 1'b0;
    logic [mfrl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mfrl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic                             kind      = mfrl_pkg::KIND_PROTECT;
    logic [mfrl_pkg::FAULT_ID_W-1:0]  fault_id  = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             fault_active;
    logic                             clear_request;
    logic                             protect_request;

    // predictor state, kept in step with every accepted beat
    logic [mfrl_pkg::BUDGET_W-1:0]   err_left  [1:NUM_IDS-1];
    logic [mfrl_pkg::BUDGET_W-1:0]   prot_left [1:NUM_IDS-1];
    logic [mfrl_pkg::FAULT_ID_W-1:0] held_id;
    logic [mfrl_pkg::TIMER_W-1:0]    quiet_timer;
    logic [mfrl_pkg::BUDGET_W-1:0]   cfg_retry;
    logic [mfrl_pkg::TIMER_W-1:0]    cfg_release;

    // expected results in beat order
    mfrl_pkg::result_t expected_responses [$];
    stim_row_t         directed_rows [$];

    // run bookkeeping
    int errors        = 0;
    int cycle_count   = 0;
    int result_count  = 0;
    int random_count  = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 66;
    int pressure_seq  = 0;
    int pressure_seen = 0;
    int hold_left     = 0;

    motor_fault_retry_lockout_core #(
        .NUM_FAULT_IDS(NUM_IDS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .fault_id       (fault_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fault_active   (fault_active),
        .clear_request  (clear_request),
        .protect_request(protect_request)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // every budget back to the retry limit, timer reloaded
    function automatic void restore_budgets();
        for (int i = 1; i < NUM_IDS; i++)
        begin
            err_left[i]  = cfg_retry;
            prot_left[i] = cfg_retry;
        end
        quiet_timer = cfg_release;
    endfunction

    // any budget below the current retry limit
    function automatic logic budgets_touched();
        for (int i = 1; i < NUM_IDS; i++)
        begin
            if (err_left[i] < cfg_retry || prot_left[i] < cfg_retry)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // ids that still have error budget left
    function automatic int live_ids();
        int n;
        n = 0;
        for (int i = 1; i < NUM_IDS; i++)
        begin
            if (err_left[i] != 0)
                n++;
        end
        return n;
    endfunction

    // result of one beat, state updated as the block does
    function automatic mfrl_pkg::result_t fault_response(
        input logic k, input logic [mfrl_pkg::FAULT_ID_W-1:0] id);
        mfrl_pkg::result_t r;
        r = '0;
        if (k == mfrl_pkg::KIND_PROTECT)
        begin
            // id zero is no fault and leaves everything alone
            if (id != 0 && int'(id) < NUM_IDS)
            begin
                held_id = id;
                if (prot_left[id] != 0)
                begin
                    prot_left[id]   = prot_left[id] - 1'b1;
                    r.clear_request = 1'b1;
                end
                else
                begin
                    // protect budget spent: refill it and burn one error
                    prot_left[id] = cfg_retry;
                    if (err_left[id] != 0)
                        err_left[id] = err_left[id] - 1'b1;
                    r.protect_request = 1'b1;
                    r.fault_active    = 1'b1;
                end
            end
        end
        else if (held_id != 0)
        begin
            // lockout while the latched id has no error budget
            if (int'(held_id) < NUM_IDS && err_left[held_id] == 0)
                r.fault_active = 1'b1;
            else
                held_id = '0;
        end
        else
        begin
            if (quiet_timer != 0)
                quiet_timer = quiet_timer - 1'b1;
            else
                restore_budgets();
            if (!budgets_touched())
                quiet_timer = cfg_release;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report(input string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        errors++;
    endtask

    // results are compared at the edge that accepts them
    always @(posedge clk)
    begin
        mfrl_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_responses.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                want = expected_responses.pop_front();
                if (fault_active !== want.fault_active)
                    report($sformatf("fault_active got %b want %b",
                                     fault_active, want.fault_active));
                if (clear_request !== want.clear_request)
                    report($sformatf("clear_request got %b want %b",
                                     clear_request, want.clear_request));
                if (protect_request !== want.protect_request)
                    report($sformatf("protect_request got %b want %b",
                                     protect_request, want.protect_request));
            end
            result_count++;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (pressure_seen != pressure_seq)
        begin
            pressure_seen <= pressure_seq;
            hold_left     <= HOLD_CYCLES;
            out_stall     <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // offer one beat, wait for the handshake, then record what it should give
    task automatic send_beat(input logic k, input logic [mfrl_pkg::FAULT_ID_W-1:0] id,
                             input logic has_want, input mfrl_pkg::result_t want);
        mfrl_pkg::result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        fault_id <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = fault_response(k, id);
        expected_responses.push_back(has_want ? want : predicted);
    endtask

    // random beat with idle mode and pressure picked from its position
    task automatic send_random(input logic k, input logic [mfrl_pkg::FAULT_ID_W-1:0] id);
        logic kk;
        kk = k;
        // never spend the last error budgets: a full lockout cannot be undone
        if (k == mfrl_pkg::KIND_PROTECT && id != 0 && prot_left[id] == 0
            && err_left[id] == 1 && live_ids() <= 2)
            kk = mfrl_pkg::KIND_TICK;
        if (random_count < 350)
        begin
            send_idle_pct = 20;
            recv_idle_pct = 66;
        end
        else if (random_count < 700)
        begin
            send_idle_pct = 66;
            recv_idle_pct = 20;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        // long output hold-off while the sender keeps pushing
        if (random_count == PRESSURE_AT)
            pressure_seq++;
        send_beat(kk, id, 1'b0, '0);
        random_count++;
    endtask

    // stop offering and let every expected result come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mfrl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mfrl_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == mfrl_pkg::REG_RETRY_LIMIT)
            cfg_retry = val[mfrl_pkg::BUDGET_W-1:0];
        else
            cfg_release = val[mfrl_pkg::TIMER_W-1:0];
    endtask

    task automatic add_beat(input logic k, input logic [mfrl_pkg::FAULT_ID_W-1:0] id,
                            input logic has_want, input mfrl_pkg::result_t want);
        directed_rows.push_back('{op: ROW_BEAT, k: k, id: id, has_want: has_want,
                                  want: want, reg_idx: '0, reg_val: '0});
    endtask

    task automatic add_write(input logic [mfrl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mfrl_pkg::CFG_DATA_W-1:0] val);
        directed_rows.push_back('{op: ROW_WRITE, k: mfrl_pkg::KIND_PROTECT, id: '0,
                                  has_want: 1'b0, want: '0, reg_idx: idx, reg_val: val});
    endtask

    initial
    begin
        int                              target;
        int                              n;
        int                              pick;
        int                              cap;
        logic [mfrl_pkg::FAULT_ID_W-1:0] pid;
        logic [mfrl_pkg::BUDGET_W-1:0]   lim_val;
        logic [mfrl_pkg::TIMER_W-1:0]    rel_val;

        // predictor comes out of reset like the block
        cfg_retry   = mfrl_pkg::RETRY_LIMIT_RESET;
        cfg_release = mfrl_pkg::RELEASE_TICKS_RESET;
        held_id     = '0;
        restore_budgets();

        // directed table, reset settings first
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd0,  1'b1, mfrl_pkg::result_t'(3'b000)); // no fault
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b1, mfrl_pkg::result_t'(3'b000));
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd1,  1'b1, mfrl_pkg::result_t'(3'b010)); // retries
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd1,  1'b1, mfrl_pkg::result_t'(3'b010));
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd1,  1'b1, mfrl_pkg::result_t'(3'b010));
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd1,  1'b1, mfrl_pkg::result_t'(3'b101)); // spent
        add_beat(mfrl_pkg::KIND_TICK,    4'd15, 1'b1, mfrl_pkg::result_t'(3'b000)); // released
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd15, 1'b1, mfrl_pkg::result_t'(3'b010)); // top id
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd15, 1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd7,  1'b0, '0);
        // new limit leaves the budgets as they are
        add_write(mfrl_pkg::REG_RETRY_LIMIT, 24'd255);
        add_write(mfrl_pkg::REG_RELEASE_TICKS, 24'd1);
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd2,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        // zero release: timer expiry refills everything at 255
        add_write(mfrl_pkg::REG_RELEASE_TICKS, 24'd0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd3,  1'b0, '0);
        add_write(mfrl_pkg::REG_RETRY_LIMIT, 24'd0);
        add_write(mfrl_pkg::REG_RELEASE_TICKS, 24'hFF_FFFF);
        add_beat(mfrl_pkg::KIND_PROTECT, 4'd3,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);
        add_beat(mfrl_pkg::KIND_TICK,    4'd0,  1'b0, '0);

        // reset held low, then released on a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_WRITE)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_beat(directed_rows[i].k, directed_rows[i].id,
                          directed_rows[i].has_want, directed_rows[i].want);
        end

        // random phases, one register setting each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    lim_val = 8'd2;
                    rel_val = 24'd0;
                end
                1:
                begin
                    lim_val = 8'd1;
                    rel_val = 24'd3;
                end
                2:
                begin
                    lim_val = 8'd3;
                    rel_val = 24'd5;
                end
                3:
                begin
                    lim_val = 8'd255;
                    rel_val = 24'hFF_FFFF;
                end
                4:
                begin
                    lim_val = 8'd2;
                    rel_val = 24'd0;
                end
                5:
                begin
                    lim_val = 8'($urandom_range(6, 1));
                    rel_val = 24'($urandom_range(12, 0));
                end
                6:
                begin
                    lim_val = 8'($urandom_range(255, 1));
                    rel_val = 24'($urandom_range(24'hFF_FFFF, 0));
                end
                default:
                begin
                    lim_val = 8'd0;
                    rel_val = 24'd2;
                end
            endcase
            wait_drained();
            write_reg(mfrl_pkg::REG_RETRY_LIMIT, mfrl_pkg::CFG_DATA_W'(lim_val));
            write_reg(mfrl_pkg::REG_RELEASE_TICKS, mfrl_pkg::CFG_DATA_W'(rel_val));

            target = random_count + PHASE_BEATS;
            while (random_count < target)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    // fault burst on one id, closed by a tick
                    pid = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 1))
                                                   : 4'($urandom_range(4, 1));
                    cap = (int'(cfg_retry) + 2 > 6) ? 6 : int'(cfg_retry) + 2;
                    n   = $urandom_range(cap, 1);
                    repeat (n)
                        send_random(mfrl_pkg::KIND_PROTECT, pid);
                    send_random(mfrl_pkg::KIND_TICK, 4'($urandom_range(15)));
                end
                else if (pick < 85)
                begin
                    // quiet run of random length, which can reach timer expiry for short release settings
                    cap = (cfg_release > 8) ? 10 : int'(cfg_release) + 2;
                    n   = $urandom_range(cap, 1);
                    repeat (n)
                        send_random(mfrl_pkg::KIND_TICK, 4'($urandom_range(15)));
                end
                else
                    send_random(1'($urandom_range(1)), 4'($urandom_range(15)));
            end
        end

        // drain and give the output stages time to show any stray beat
        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/mfrl_pkg.sv
sv/motor_fault_retry_lockout_core.sv
verif/tb.sv
